// ----- sv/vector3_euler_rotate_unit_defines.svh -----
// Assertion macros for the Euler rotation unit.
// Included by the checker; expects clk and rst_n in the enclosing scope.
`ifndef VECTOR3_EULER_ROTATE_UNIT_DEFINES_SVH
`define VECTOR3_EULER_ROTATE_UNIT_DEFINES_SVH

// Overlapping implication, sampled on the rising clock edge.
`define VEROT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// Non-overlapping implication, sampled on the rising clock edge.
`define VEROT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error(msg);

`endif

// ----- sv/verot_pkg.sv -----
// Shared types, constants and arithmetic helpers of the Euler rotation unit.
// No dependencies; every other file except the defines header imports this package.
package verot_pkg;

  localparam int WORD_W   = 32;
  localparam int FRAC_DEF = 16;

  // pi/180 in Q30 and unity in Q30
  localparam logic [24:0] RAD_Q30 = 25'd18740330;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  localparam int SC_LAT  = 11;
  localparam int MAT_LAT = 3;
  localparam int ROW_LAT = 3;

  // Exact reciprocals for values below 2^30: q = (v * RCP) >> SH.
  localparam int SIN_SH [4] = '{37, 36, 35, 33};
  localparam logic [31:0] SIN_RCP [4] = '{
    32'(((64'd1 << 37) + 64'd71) / 64'd72),
    32'(((64'd1 << 36) + 64'd41) / 64'd42),
    32'(((64'd1 << 35) + 64'd19) / 64'd20),
    32'(((64'd1 << 33) + 64'd5) / 64'd6)
  };
  localparam int COS_SH [4] = '{37, 36, 35, 34};
  localparam logic [31:0] COS_RCP [4] = '{
    32'(((64'd1 << 37) + 64'd89) / 64'd90),
    32'(((64'd1 << 36) + 64'd55) / 64'd56),
    32'(((64'd1 << 35) + 64'd29) / 64'd30),
    32'(((64'd1 << 34) + 64'd11) / 64'd12)
  };

  typedef logic [30:0]        q30_t;
  typedef logic signed [31:0] sq30_t;
  typedef logic signed [32:0] mel_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } verot_quad_t;

  typedef struct packed {
    logic        valid;
    verot_quad_t quad;
    logic        fold;
  } verot_ang_ctl_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] vec_x;
    logic signed [WORD_W-1:0] vec_y;
    logic signed [WORD_W-1:0] vec_z;
    logic signed [WORD_W-1:0] angle_x_deg;
    logic signed [WORD_W-1:0] angle_y_deg;
    logic signed [WORD_W-1:0] angle_z_deg;
  } verot_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] vec_x;
    logic signed [WORD_W-1:0] vec_y;
    logic signed [WORD_W-1:0] vec_z;
  } verot_vec_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] rot_x;
    logic signed [WORD_W-1:0] rot_y;
    logic signed [WORD_W-1:0] rot_z;
  } verot_out_t;

  // Pipeline stages of the modulo-360 reduction: eight bits per stage.
  function automatic int verot_mod_stages(int frac);
    return (WORD_W - frac + 17) >> 3;
  endfunction

  function automatic int verot_latency(int frac);
    return verot_mod_stages(frac) + 2 + SC_LAT + MAT_LAT + ROW_LAT;
  endfunction

  function automatic q30_t mulq30(q30_t a, q30_t b);
    logic [63:0] p;
    p = 64'(a) * 64'(b) + (64'd1 << 29);
    return q30_t'(p >> 30);
  endfunction

  function automatic q30_t div_rcp(q30_t v, logic [31:0] rcp, int sh);
    logic [63:0] p;
    p = 64'(v) * 64'(rcp);
    return q30_t'(p >> sh);
  endfunction

  // Signed Q30 product: the magnitude is rounded, then the sign applied.
  function automatic sq30_t smul(sq30_t a, sq30_t b);
    q30_t  ma;
    q30_t  mb;
    sq30_t p;
    ma = q30_t'(a[31] ? -a : a);
    mb = q30_t'(b[31] ? -b : b);
    p  = $signed({1'b0, mulq30(ma, mb)});
    return (a[31] ^ b[31]) ? -p : p;
  endfunction

endpackage

// ----- sv/vector3_euler_rotate_unit.sv -----
// Euler-angle rotation of a 3D vector: top level.
// Instantiates verot_angle_reduce, verot_sincos, verot_matrix and verot_rows; uses verot_pkg.
//
// Usage:
//   A beat is offered on in_data with start high; it is taken at every rising edge
//   where start is high and busy is low. busy is never raised, so a new beat may be
//   offered in every cycle and the unit sustains one beat per clock.
//   Each accepted beat yields exactly one result beat on out_data, marked by
//   out_valid for a single cycle, in the order the beats were taken.
//   The modulo-360 reduction takes eight bits of the integer part per stage
//   (FRAC_BITS defaults to 16), the sine and cosine polynomials take one
//   multiply or one reciprocal divide per stage (eleven stages), the matrix
//   three and the row products with rounding and saturation three.
//   A synchronous active-low reset clears every valid bit; beats in flight are
//   dropped and out_valid stays low until new beats have run through.
//   The receiver cannot hold results off, so nothing inside ever stalls.
module vector3_euler_rotate_unit import verot_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  verot_in_t  in_data,
  output logic       out_valid,
  output verot_out_t out_data
);

  localparam int LAT_V = verot_mod_stages(FRAC_BITS) + 2 + SC_LAT + MAT_LAT;

  logic                 accept;
  verot_ang_ctl_t       ctl_x, ctl_y, ctl_z;
  logic [FRAC_BITS+5:0] r_x, r_y, r_z;
  logic                 sv_x, sv_y, sv_z;
  sq30_t                sa, ca, sb, cb, sc, cc;
  logic                 m_valid;
  mel_t                 m [9];
  verot_vec_t           vd_r [LAT_V];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  verot_angle_reduce #(.FRAC_BITS(FRAC_BITS)) u_red_x (
    .clk(clk), .rst_n(rst_n), .valid_i(accept), .angle_i(in_data.angle_x_deg),
    .ctl_o(ctl_x), .r_o(r_x)
  );
  verot_angle_reduce #(.FRAC_BITS(FRAC_BITS)) u_red_y (
    .clk(clk), .rst_n(rst_n), .valid_i(accept), .angle_i(in_data.angle_y_deg),
    .ctl_o(ctl_y), .r_o(r_y)
  );
  verot_angle_reduce #(.FRAC_BITS(FRAC_BITS)) u_red_z (
    .clk(clk), .rst_n(rst_n), .valid_i(accept), .angle_i(in_data.angle_z_deg),
    .ctl_o(ctl_z), .r_o(r_z)
  );

  verot_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_x (
    .clk(clk), .rst_n(rst_n), .ctl_i(ctl_x), .r_i(r_x), .valid_o(sv_x), .s_o(sa), .c_o(ca)
  );
  verot_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_y (
    .clk(clk), .rst_n(rst_n), .ctl_i(ctl_y), .r_i(r_y), .valid_o(sv_y), .s_o(sb), .c_o(cb)
  );
  verot_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_z (
    .clk(clk), .rst_n(rst_n), .ctl_i(ctl_z), .r_i(r_z), .valid_o(sv_z), .s_o(sc), .c_o(cc)
  );

  // The three angle paths run in lock step, so their valid bits agree.
  verot_matrix u_mat (
    .clk(clk), .rst_n(rst_n), .valid_i(sv_x && sv_y && sv_z),
    .sa_i(sa), .ca_i(ca), .sb_i(sb), .cb_i(cb), .sc_i(sc), .cc_i(cc),
    .valid_o(m_valid), .m_o(m)
  );

  always_ff @(posedge clk) begin
    vd_r[0] <= '{vec_x: in_data.vec_x, vec_y: in_data.vec_y, vec_z: in_data.vec_z};
    for (int i = 1; i < LAT_V; i++) begin
      vd_r[i] <= vd_r[i-1];
    end
  end

  verot_rows u_rows (
    .clk(clk), .rst_n(rst_n), .valid_i(m_valid), .vec_i(vd_r[LAT_V-1]), .m_i(m),
    .valid_o(out_valid), .out_o(out_data)
  );

endmodule

// ----- sv/verot_angle_reduce.sv -----
// Angle reduction: modulo 360 degrees, quadrant and fold into the first octant.
// Depends on verot_pkg.
module verot_angle_reduce import verot_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_i,
  input  logic signed [WORD_W-1:0] angle_i,
  output verot_ang_ctl_t           ctl_o,
  output logic [FRAC_BITS+5:0]     r_o
);

  localparam int HW   = WORD_W - FRAC_BITS;
  localparam int KM   = verot_mod_stages(FRAC_BITS);
  localparam int PW   = KM * 8;
  localparam int OFFS = 360 * ((2 ** (HW - 1) + 359) / 360);
  localparam logic [FRAC_BITS+6:0] QUARTER = (FRAC_BITS + 7)'(90) << FRAC_BITS;
  localparam logic [FRAC_BITS+6:0] EIGHTH  = (FRAC_BITS + 7)'(45) << FRAC_BITS;

  logic [PW-1:0]        u_r   [KM+1];
  logic [8:0]           rem_r [KM+1];
  logic [FRAC_BITS-1:0] lo_r  [KM+1];
  logic                 vld_r [KM+1];
  logic [PW-1:0]        u_nxt;

  logic                 vq_r;
  verot_quad_t          quad_r;
  verot_quad_t          quad_nxt;
  logic                 fold_r;
  logic                 fold_nxt;
  logic [FRAC_BITS+5:0] r_r;
  logic [FRAC_BITS+5:0] r_nxt;

  // An offset that is a multiple of 360 makes the integer part non-negative.
  assign u_nxt = PW'($signed(angle_i[WORD_W-1:FRAC_BITS])) + PW'(OFFS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    u_r[0]   <= u_nxt;
    lo_r[0]  <= angle_i[FRAC_BITS-1:0];
    rem_r[0] <= '0;
  end

  for (genvar k = 0; k < KM; k++) begin : g_mod
    logic [8:0] rem_nxt;

    always_comb begin : p_rem
      logic [9:0] acc;
      acc = {1'b0, rem_r[k]};
      for (int b = 0; b < 8; b++) begin
        acc = {acc[8:0], u_r[k][PW-1-8*k-b]};
        if (acc >= 10'd360) begin
          acc = acc - 10'd360;
        end
      end
      rem_nxt = acc[8:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      u_r[k+1]   <= u_r[k];
      lo_r[k+1]  <= lo_r[k];
      rem_r[k+1] <= rem_nxt;
    end
  end

  always_comb begin : p_quad
    logic [8:0]           ri;
    logic [FRAC_BITS+6:0] rfull;
    logic [FRAC_BITS+6:0] rsel;
    if (rem_r[KM] >= 9'd270) begin
      quad_nxt = QUAD_3;
      ri       = rem_r[KM] - 9'd270;
    end else if (rem_r[KM] >= 9'd180) begin
      quad_nxt = QUAD_2;
      ri       = rem_r[KM] - 9'd180;
    end else if (rem_r[KM] >= 9'd90) begin
      quad_nxt = QUAD_1;
      ri       = rem_r[KM] - 9'd90;
    end else begin
      quad_nxt = QUAD_0;
      ri       = rem_r[KM];
    end
    rfull    = {ri[6:0], lo_r[KM]};
    fold_nxt = rfull > EIGHTH;
    rsel     = fold_nxt ? (QUARTER - rfull) : rfull;
    r_nxt    = rsel[FRAC_BITS+5:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
    end else begin
      vq_r <= vld_r[KM];
    end
  end

  always_ff @(posedge clk) begin
    quad_r <= quad_nxt;
    fold_r <= fold_nxt;
    r_r    <= r_nxt;
  end

  assign ctl_o = '{valid: vq_r, quad: quad_r, fold: fold_r};
  assign r_o   = r_r;

endmodule

// ----- sv/verot_sincos.sv -----
// Sine and cosine of a folded angle by fixed-length polynomials, one step per stage.
// Depends on verot_pkg.
module verot_sincos import verot_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  verot_ang_ctl_t       ctl_i,
  input  logic [FRAC_BITS+5:0] r_i,
  output logic                 valid_o,
  output sq30_t                s_o,
  output sq30_t                c_o
);

  localparam int RW = FRAC_BITS + 6;
  localparam int PW = RW + 26;

  logic [PW-1:0]  xp;
  q30_t           xa_r;
  logic           va_r;
  verot_ang_ctl_t ca_r;

  q30_t           vs_r [9];
  q30_t           vc_r [9];
  q30_t           xd_r [9];
  q30_t           x2_r [9];
  verot_ang_ctl_t cq_r [9];
  logic           vl_r [9];

  logic           vo_r;
  sq30_t          s_r;
  sq30_t          c_r;
  sq30_t          s_nxt;
  sq30_t          c_nxt;

  // Degrees to radians, rounded to Q30.
  assign xp = PW'(r_i) * PW'(RAD_Q30) + (PW'(1) << (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r    <= 1'b0;
      vl_r[0] <= 1'b0;
    end else begin
      va_r    <= ctl_i.valid;
      vl_r[0] <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    xa_r    <= q30_t'(xp >> FRAC_BITS);
    ca_r    <= ctl_i;
    xd_r[0] <= xa_r;
    x2_r[0] <= mulq30(xa_r, xa_r);
    vs_r[0] <= mulq30(xa_r, xa_r);
    vc_r[0] <= mulq30(xa_r, xa_r);
    cq_r[0] <= ca_r;
  end

  // Odd stages divide by a constant, even stages multiply by x^2 (x last for sine).
  for (genvar k = 1; k < 9; k++) begin : g_step
    q30_t vs_nxt;
    q30_t vc_nxt;

    if (k % 2 == 1) begin : g_div
      assign vs_nxt = ONE_Q30 - div_rcp(vs_r[k-1], SIN_RCP[(k-1)/2], SIN_SH[(k-1)/2]);
      assign vc_nxt = ONE_Q30 - div_rcp(vc_r[k-1], COS_RCP[(k-1)/2], COS_SH[(k-1)/2]);
    end else if (k == 8) begin : g_last
      assign vs_nxt = mulq30(xd_r[k-1], vs_r[k-1]);
      assign vc_nxt = mulq30(x2_r[k-1], vc_r[k-1]);
    end else begin : g_mul
      assign vs_nxt = mulq30(x2_r[k-1], vs_r[k-1]);
      assign vc_nxt = mulq30(x2_r[k-1], vc_r[k-1]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vl_r[k] <= 1'b0;
      end else begin
        vl_r[k] <= vl_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      vs_r[k] <= vs_nxt;
      vc_r[k] <= vc_nxt;
      xd_r[k] <= xd_r[k-1];
      x2_r[k] <= x2_r[k-1];
      cq_r[k] <= cq_r[k-1];
    end
  end

  always_comb begin : p_quad
    q30_t  cu;
    sq30_t sp;
    sq30_t cp;
    cu = ONE_Q30 - (vc_r[8] >> 1);
    sp = $signed({1'b0, cq_r[8].fold ? cu : vs_r[8]});
    cp = $signed({1'b0, cq_r[8].fold ? vs_r[8] : cu});
    case (cq_r[8].quad)
      QUAD_0: begin
        s_nxt = sp;
        c_nxt = cp;
      end
      QUAD_1: begin
        s_nxt = cp;
        c_nxt = -sp;
      end
      QUAD_2: begin
        s_nxt = -sp;
        c_nxt = -cp;
      end
      default: begin
        s_nxt = -cp;
        c_nxt = sp;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= vl_r[8];
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
    c_r <= c_nxt;
  end

  assign valid_o = vo_r;
  assign s_o     = s_r;
  assign c_o     = c_r;

endmodule

// ----- sv/verot_matrix.sv -----
// Rotation matrix Rz*Ry*Rx from the sines and cosines, three register stages.
// Depends on verot_pkg.
module verot_matrix import verot_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  valid_i,
  input  sq30_t sa_i,
  input  sq30_t ca_i,
  input  sq30_t sb_i,
  input  sq30_t cb_i,
  input  sq30_t sc_i,
  input  sq30_t cc_i,
  output logic  valid_o,
  output mel_t  m_o [9]
);

  logic  v1_r;
  logic  v2_r;
  logic  v3_r;
  sq30_t sab_r, cab_r, m0_r, casc_r, sasc_r, m3_r, cacc_r, sacc_r, m7_r, m8_r, m6_r;
  sq30_t sc1_r, cc1_r;
  sq30_t p1_r, p2_r, p4_r, p5_r;
  sq30_t m0b_r, cascb_r, sascb_r, m3b_r, caccb_r, saccb_r, m6b_r, m7b_r, m8b_r;
  mel_t  m_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    sab_r  <= smul(sa_i, sb_i);
    cab_r  <= smul(ca_i, sb_i);
    m0_r   <= smul(cb_i, cc_i);
    casc_r <= smul(ca_i, sc_i);
    sasc_r <= smul(sa_i, sc_i);
    m3_r   <= smul(cb_i, sc_i);
    cacc_r <= smul(ca_i, cc_i);
    sacc_r <= smul(sa_i, cc_i);
    m7_r   <= smul(sa_i, cb_i);
    m8_r   <= smul(ca_i, cb_i);
    m6_r   <= -sb_i;
    sc1_r  <= sc_i;
    cc1_r  <= cc_i;

    p1_r    <= smul(sab_r, cc1_r);
    p2_r    <= smul(cab_r, cc1_r);
    p4_r    <= smul(sab_r, sc1_r);
    p5_r    <= smul(cab_r, sc1_r);
    m0b_r   <= m0_r;
    cascb_r <= casc_r;
    sascb_r <= sasc_r;
    m3b_r   <= m3_r;
    caccb_r <= cacc_r;
    saccb_r <= sacc_r;
    m6b_r   <= m6_r;
    m7b_r   <= m7_r;
    m8b_r   <= m8_r;

    m_r[0] <= mel_t'(m0b_r);
    m_r[1] <= mel_t'(p1_r) - mel_t'(cascb_r);
    m_r[2] <= mel_t'(p2_r) + mel_t'(sascb_r);
    m_r[3] <= mel_t'(m3b_r);
    m_r[4] <= mel_t'(p4_r) + mel_t'(caccb_r);
    m_r[5] <= mel_t'(p5_r) - mel_t'(saccb_r);
    m_r[6] <= mel_t'(m6b_r);
    m_r[7] <= mel_t'(m7b_r);
    m_r[8] <= mel_t'(m8b_r);
  end

  assign valid_o = v3_r;
  assign m_o     = m_r;

endmodule

// ----- sv/verot_rows.sv -----
// Matrix times vector with rounding and saturation, three register stages.
// Depends on verot_pkg.
module verot_rows import verot_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       valid_i,
  input  verot_vec_t vec_i,
  input  mel_t       m_i [9],
  output logic       valid_o,
  output verot_out_t out_o
);

  localparam int PRW = WORD_W + 33;
  localparam int SW  = PRW + 2;
  localparam int TW  = SW - 30;
  localparam logic signed [TW-1:0] MAXP = TW'((64'd1 << (WORD_W - 1)) - 64'd1);
  localparam logic signed [TW-1:0] MINN = -MAXP - TW'(1);

  logic signed [WORD_W-1:0] v [3];
  logic signed [PRW-1:0]    p_r [9];
  logic signed [SW-1:0]     acc_r [3];
  logic signed [WORD_W-1:0] res_r [3];
  logic                     v1_r;
  logic                     v2_r;
  logic                     v3_r;

  assign v[0] = vec_i.vec_x;
  assign v[1] = vec_i.vec_y;
  assign v[2] = vec_i.vec_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  for (genvar i = 0; i < 9; i++) begin : g_prod
    always_ff @(posedge clk) begin
      p_r[i] <= PRW'(v[i % 3]) * PRW'(m_i[i]);
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_row
    logic signed [TW-1:0]     sh;
    logic signed [WORD_W-1:0] sat;

    // Floor shift after adding half an LSB, then clamp to the word range.
    assign sh  = TW'(acc_r[j] >>> 30);
    assign sat = (sh > MAXP) ? WORD_W'(MAXP) : (sh < MINN) ? WORD_W'(MINN) : WORD_W'(sh);

    always_ff @(posedge clk) begin
      acc_r[j] <= SW'(p_r[3*j]) + SW'(p_r[3*j+1]) + SW'(p_r[3*j+2]) + (SW'(1) << 29);
      res_r[j] <= sat;
    end
  end

  assign valid_o = v3_r;
  assign out_o   = '{rot_x: res_r[0], rot_y: res_r[1], rot_z: res_r[2]};

endmodule

// ----- sv/verot_checker.sv -----
// Port-level checker of the Euler rotation unit and its bind to the top level.
// Depends on verot_pkg and vector3_euler_rotate_unit_defines.svh.
`include "vector3_euler_rotate_unit_defines.svh"

module verot_checker import verot_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEF
) (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input verot_in_t  in_data,
  input logic       out_valid,
  input verot_out_t out_data
);

  localparam int LAT = verot_latency(FRAC_BITS);

  `VEROT_ASSERT_NXT(a_never_busy, 1'b1, !busy, "busy raised")
  `VEROT_ASSERT_IMP(a_result_has_beat, out_valid, $past(start && !busy, LAT), "result without beat")
  `VEROT_ASSERT_IMP(a_beat_has_result, start && !busy, ##LAT out_valid, "beat without result")
  `VEROT_ASSERT_IMP(a_zero_vector, out_valid && $past(in_data.vec_x == 0 && in_data.vec_y == 0 && in_data.vec_z == 0, LAT), out_data == '0, "zero vector not kept")

endmodule

bind vector3_euler_rotate_unit verot_checker #(.FRAC_BITS(FRAC_BITS)) u_verot_checker (.*);
